>>> design/region_table_bump_allocator_unit_defines.svh
// Assertion macros for the region table bump allocator.
// Included by the top level; expects clk and rst_n in scope at the use site.
`ifndef REGION_TABLE_BUMP_ALLOCATOR_UNIT_DEFINES_SVH
`define REGION_TABLE_BUMP_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define RTBA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset
`define RTBA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RTBA_ASSERT_IMPL(name, ante, cons, msg)
`define RTBA_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

>>> design/rtba_pkg.sv
// Shared types, codes and constants for the region table bump allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rtba_pkg;

    // Sizes
    localparam int TABLE_DEPTH_DEF = 512;
    localparam int ADDR_W          = 32;
    localparam int GRANULE_SHIFT   = 10;  // request granule of 1024 bytes
    localparam int PAGE_SHIFT      = 12;  // page of 4096 bytes
    localparam int PAGE_W          = ADDR_W - GRANULE_SHIFT + 1;
    localparam int SUM_W           = PAGE_W + PAGE_SHIFT + 1;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REGIDX_W = PADDR_W - 2;
    localparam logic [REGIDX_W-1:0] REG_POOL_BASE = '0;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_CHECK   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_NO_SPACE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        action_t           action;
        logic [ADDR_W-1:0] request_size;
        logic [ADDR_W-1:0] address;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] region_address;
        logic              in_region;
        status_t           status;
    } result_t;

    // One table row: region start and its inclusive end (start + length)
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] last;
    } row_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        row_t wr_row;
    } mem_ctl_t;

endpackage

`default_nettype wire

>>> design/rtba_mem.sv
// Region table storage: one write port, one registered read port.
// Depends on rtba_pkg for the row and control types.
`timescale 1ns / 1ps
`default_nettype none

module rtba_mem #(
    parameter int DEPTH = rtba_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = 9
) (
    input  wire logic              clk,
    input  wire rtba_pkg::mem_ctl_t ctl,
    input  wire logic [IDX_W-1:0]  rd_addr,
    input  wire logic [IDX_W-1:0]  wr_addr,
    output rtba_pkg::row_t         rd_row
);
    import rtba_pkg::*;

    row_t rows_reg [DEPTH];
    row_t rd_row_reg;

    // Write one row
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            rows_reg[wr_addr] <= ctl.wr_row;
        end
    end

    // Read one row, registered
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_row_reg <= rows_reg[rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

`default_nettype wire

>>> design/rtba_match.sv
// Shared compare unit: tests one table row against the key of the command.
// Depends on rtba_pkg for the row type.
`timescale 1ns / 1ps
`default_nettype none

module rtba_match (
    input  wire rtba_pkg::row_t                  row,
    input  wire logic [rtba_pkg::ADDR_W-1:0]     key,
    input  wire logic                            exact,
    output logic                                 hit
);
    import rtba_pkg::*;

    logic eq_start;
    logic in_range;

    // Release matches the start exactly; check accepts both ends of the region
    always_comb
    begin
        eq_start = (row.start == key);
        in_range = (key >= row.start) && (key <= row.last);
        hit      = row.valid && (exact ? eq_start : in_range);
    end

endmodule

`default_nettype wire

>>> design/rtba_seq.sv
// Sequencer: command capture, allocation arithmetic and the table scan.
// Depends on rtba_pkg; drives rtba_mem and reads the rtba_match result.
`timescale 1ns / 1ps
`default_nettype none

module rtba_seq #(
    parameter int TABLE_DEPTH = rtba_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W       = 9,
    parameter int CNT_W       = 10
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire rtba_pkg::cmd_t               cmd,
    input  wire logic                         cfg_wr,
    input  wire logic [rtba_pkg::ADDR_W-1:0]  cfg_data,
    input  wire logic                         hit,
    output logic                              busy,
    output logic                              done,
    output rtba_pkg::result_t                 result,
    output rtba_pkg::mem_ctl_t                mem_ctl,
    output logic [IDX_W-1:0]                  rd_addr,
    output logic [IDX_W-1:0]                  wr_addr,
    output logic [rtba_pkg::ADDR_W-1:0]       key,
    output logic                              exact
);
    import rtba_pkg::*;

    state_t              state_reg,     state_next;
    cmd_t                cmd_reg,       cmd_next;
    logic [CNT_W-1:0]    used_reg,      used_next;
    logic [ADDR_W-1:0]   next_free_reg, next_free_next;
    logic [CNT_W-1:0]    issue_reg,     issue_next;
    logic                pend_reg,      pend_next;
    logic [IDX_W-1:0]    pidx_reg,      pidx_next;
    result_t             res_reg,       res_next;

    logic [PAGE_W-1:0]   pages;
    logic [SUM_W-1:0]    end_sum;
    logic                table_full;
    logic                no_space;

    // Region length and end address for an allocate
    always_comb
    begin
        pages      = PAGE_W'(cmd_reg.request_size >> GRANULE_SHIFT) + PAGE_W'(1);
        end_sum    = SUM_W'(next_free_reg) + (SUM_W'(pages) << PAGE_SHIFT);
        no_space   = |end_sum[SUM_W-1:ADDR_W];
        table_full = (used_reg >= CNT_W'(TABLE_DEPTH));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.action)
                        ACT_ALLOC:   state_next = ST_ALLOC;
                        ACT_RELEASE,
                        ACT_CHECK:   state_next = (used_reg == '0) ? ST_FINISH : ST_SCAN;
                        default:     state_next = ST_FINISH;
                    endcase
                end
            end
            ST_ALLOC:  state_next = ST_FINISH;
            ST_SCAN:
            begin
                // last row issued; its compare commits at this edge
                if (issue_reg == used_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and table control
    always_comb
    begin
        cmd_next       = cmd_reg;
        used_next      = used_reg;
        next_free_next = next_free_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        res_next       = res_reg;
        mem_ctl        = '0;
        rd_addr        = issue_reg[IDX_W-1:0];
        wr_addr        = pidx_reg;

        // Pool base write restarts the free pointer
        if (cfg_wr)
        begin
            next_free_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    issue_next = '0;
                    res_next   = '{region_address: '0, in_region: 1'b0,
                                   status: STATUS_OK};
                end
            end
            ST_ALLOC:
            begin
                if (table_full)
                begin
                    res_next.status = STATUS_FULL;
                end
                else if (no_space)
                begin
                    res_next.status = STATUS_NO_SPACE;
                end
                else
                begin
                    mem_ctl.wr_en  = 1'b1;
                    mem_ctl.wr_row = '{valid: 1'b1, start: next_free_reg,
                                       last: end_sum[ADDR_W-1:0]};
                    wr_addr        = used_reg[IDX_W-1:0];
                    used_next      = used_reg + CNT_W'(1);
                    next_free_next = end_sum[ADDR_W-1:0];
                    res_next.region_address = next_free_reg;
                end
            end
            ST_SCAN:
            begin
                // Issue the next row read
                if (issue_reg != used_reg)
                begin
                    mem_ctl.rd_en = 1'b1;
                    issue_next    = issue_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pidx_next     = issue_reg[IDX_W-1:0];
                end
                // Act on the row read last cycle
                if (pend_reg && hit)
                begin
                    if (cmd_reg.action == ACT_RELEASE)
                    begin
                        mem_ctl.wr_en  = 1'b1;
                        mem_ctl.wr_row = '0;
                        wr_addr        = pidx_reg;
                    end
                    else
                    begin
                        res_next.in_region = 1'b1;
                    end
                end
            end
            ST_FINISH: ;
            default:   ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            next_free_reg <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            res_reg       <= '{region_address: '0, in_region: 1'b0, status: STATUS_OK};
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            next_free_reg <= next_free_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            res_reg       <= res_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pidx_reg <= pidx_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = (state_reg == ST_FINISH);
    assign result = res_reg;
    assign key    = cmd_reg.address;
    assign exact  = (cmd_reg.action == ACT_RELEASE);

endmodule

`default_nettype wire

>>> design/region_table_bump_allocator_unit.sv
// Region table bump allocator. Start a command with start while busy is low;
// the result appears for exactly one cycle with done high and cannot be held
// off, so the receiver must take it then. Allocate passes through the ST_ALLOC
// state before the result, the unused action code goes straight to the result,
// and release or check scan every table entry allocated so far before the
// result (no scan while no entry has been allocated yet): the scan reads one
// row per cycle through the single read port of the region table. busy stays
// high through the result cycle. pool_base sits at byte address 0 of the
// APB-style port; writing it also restarts the free pointer. Write it only
// while busy is low. Depends on rtba_pkg and the block's defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "region_table_bump_allocator_unit_defines.svh"

module region_table_bump_allocator_unit #(
    parameter int TABLE_DEPTH = rtba_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // command channel
    input  wire logic                          start,
    input  wire rtba_pkg::cmd_t                cmd,
    output logic                               busy,
    output logic                               done,
    output rtba_pkg::result_t                  result,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rtba_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [rtba_pkg::PDATA_W-1:0]  pwdata,
    output logic [rtba_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import rtba_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [ADDR_W-1:0]  pool_base_reg;
    logic [REGIDX_W-1:0] reg_idx;
    logic               pool_wr;
    mem_ctl_t           mem_ctl;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    row_t               rd_row;
    logic [ADDR_W-1:0]  key;
    logic               exact;
    logic               hit;

    // Decode register writes
    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign pool_wr = psel && penable && pwrite && pready && (reg_idx == REG_POOL_BASE);
    assign prdata  = (reg_idx == REG_POOL_BASE) ? pool_base_reg : '0;

    // Hold the pool base
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
        end
        else if (pool_wr)
        begin
            pool_base_reg <= pwdata;
        end
    end

    rtba_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .rd_row  (rd_row)
    );

    rtba_match u_match (
        .row   (rd_row),
        .key   (key),
        .exact (exact),
        .hit   (hit)
    );

    rtba_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .cfg_wr   (pool_wr),
        .cfg_data (pwdata),
        .hit      (hit),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .mem_ctl  (mem_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .key      (key),
        .exact    (exact)
    );

    // Checks
    `RTBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after transfer")
    `RTBA_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
    `RTBA_ASSERT_IMPL(a_fail_zero, done && (result.status != STATUS_OK),
                      result.region_address == '0, "failed allocate returned an address")
    `RTBA_ASSERT_IMPL(a_legit_ok, done && result.in_region,
                      result.status == STATUS_OK, "check result carries a failure status")

endmodule

`default_nettype wire

>>> dv/tb_region_table_bump_allocator_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for region_table_bump_allocator_unit: directed and random
// commands plus APB writes of pool_base, each result checked against a local shadow
// of the region table. Depends on rtba_pkg and the block's RTL only.

module tb_region_table_bump_allocator_unit;

    import rtba_pkg::*;

    localparam int     DEPTH        = TABLE_DEPTH_DEF;
    localparam int     HALF_PERIOD  = 6;
    localparam int     RESET_CYCLES = 10;
    localparam longint CYCLE_LIMIT  = 4_000_000;
    localparam int     END_WAIT     = DEPTH + 16;
    localparam int     MAX_REPORTS  = 100;
    localparam int     RANDOM_ITEMS = 940;

    // Action code outside the enum; the block must answer it with an all-zero result
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [PADDR_W-1:0] ADDR_POOL_BASE = {REG_POOL_BASE, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_BAD_REG   = {~REG_POOL_BASE, 2'b00};

    localparam logic [ADDR_W-1:0] TOP_ADDR = '1;

    typedef struct {
        cmd_t    c;
        result_t r;
    } awaited_t;

    // DUT connections, all driven from time zero
    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                start   = 1'b0;
    cmd_t                cmd     = '0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic                busy;
    logic                done;
    result_t             result;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Shadow of the region table and the free pointer
    logic [ADDR_W-1:0]   m_pool_base;
    logic [ADDR_W-1:0]   m_next_free;
    logic [ADDR_W-1:0]   m_start [DEPTH];
    logic [ADDR_W-1:0]   m_len   [DEPTH];
    bit                  m_valid [DEPTH];
    int                  m_used;

    awaited_t            awaited_results[$];
    awaited_t            head;

    int                  err_count   = 0;
    int                  n_alloc     = 0;
    int                  n_refused   = 0;
    int                  n_release   = 0;
    int                  n_check     = 0;
    int                  n_legit     = 0;
    int                  n_unused    = 0;
    int                  n_results   = 0;
    longint              cycle_count = 0;
    bit                  no_idle     = 1'b0;

    region_table_bump_allocator_unit #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("tb_region_table_bump_allocator_unit NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task automatic clear_model();
        m_pool_base = '0;
        m_next_free = '0;
        m_used      = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            m_valid[i] = 1'b0;
            m_start[i] = '0;
            m_len[i]   = '0;
        end
    endtask

    // Apply one command to the shadow table and return the result it must give
    function automatic result_t compute_outcome(input cmd_t c);
        result_t           r;
        logic [35:0]       span;
        logic [35:0]       fin;
        logic [32:0]       hi;
        r = '0;
        case (c.action)
            ACT_ALLOC:
            begin
                span = (36'(c.request_size >> GRANULE_SHIFT) + 36'd1) << PAGE_SHIFT;
                fin  = 36'(m_next_free) + span;
                if (m_used >= DEPTH)
                    r.status = STATUS_FULL;
                else if (fin > 36'(TOP_ADDR))
                    r.status = STATUS_NO_SPACE;
                else
                begin
                    m_start[m_used] = m_next_free;
                    m_len[m_used]   = span[ADDR_W-1:0];
                    m_valid[m_used] = 1'b1;
                    m_used++;
                    r.region_address = m_next_free;
                    m_next_free      = fin[ADDR_W-1:0];
                end
            end
            ACT_RELEASE:
            begin
                for (int i = 0; i < m_used; i++)
                begin
                    if (m_valid[i] && m_start[i] == c.address)
                    begin
                        m_valid[i] = 1'b0;
                        m_start[i] = '0;
                        m_len[i]   = '0;
                    end
                end
            end
            ACT_CHECK:
            begin
                for (int i = 0; i < m_used; i++)
                begin
                    hi = 33'(m_start[i]) + 33'(m_len[i]);
                    if (m_valid[i] && c.address >= m_start[i] && 33'(c.address) <= hi)
                        r.in_region = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 200);
    endfunction

    // Mostly small requests; some large ones that run out of address space
    function automatic logic [ADDR_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return $urandom_range(0, 16383);
        if (roll < 82)
            return $urandom_range(0, 32'h000F_FFFF);
        if (roll < 95)
            return $urandom();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 32'd1023;
            2:       return 32'd1024;
            default: return '1;
        endcase
    endfunction

    // Probe near the bounds of a known region, or anywhere
    function automatic logic [ADDR_W-1:0] pick_probe();
        int                idx;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        if (m_used == 0 || $urandom_range(0, 3) == 0)
            return $urandom();
        idx = $urandom_range(0, m_used - 1);
        lo  = m_start[idx];
        hi  = lo + m_len[idx];
        case ($urandom_range(0, 4))
            0:       return lo - 1;
            1:       return lo;
            2:       return hi;
            3:       return hi + 1;
            default: return lo + $urandom_range(0, m_len[idx]);
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_release_target();
        if (m_used > 0 && $urandom_range(0, 9) < 7)
            return m_start[$urandom_range(0, m_used - 1)];
        if ($urandom_range(0, 1))
            return m_next_free;
        return $urandom();
    endfunction

    // Send one command and record its expected result at the transfer edge
    task automatic send_cmd(input action_t act, input logic [ADDR_W-1:0] size,
                            input logic [ADDR_W-1:0] addr);
        cmd_t    c;
        result_t outcome;
        int      gap;
        c.action       = act;
        c.request_size = size;
        c.address      = addr;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 1))
                while (busy !== 1'b0)
                    @(negedge clk);
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        while (busy !== 1'b0)
            @(negedge clk);
        @(posedge clk);
        outcome = compute_outcome(c);
        awaited_results.push_back('{c, outcome});
        case (act)
            ACT_ALLOC:
            begin
                n_alloc++;
                if (outcome.status != STATUS_OK)
                    n_refused++;
            end
            ACT_RELEASE: n_release++;
            ACT_CHECK:
            begin
                n_check++;
                if (outcome.in_region)
                    n_legit++;
            end
            default:     n_unused++;
        endcase
    endtask

    // Drop start and hold until every result is in and the block is idle
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0 || busy !== 1'b0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (a[PADDR_W-1:2] == REG_POOL_BASE)
        begin
            m_pool_base = d;
            m_next_free = d;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_pool_base_readback();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_POOL_BASE;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (prdata !== m_pool_base)
            report_mismatch($sformatf("pool_base read %h, want %h", prdata, m_pool_base));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_pool_base(input logic [ADDR_W-1:0] value);
        settle();
        apb_write(ADDR_POOL_BASE, value);
        check_pool_base_readback();
    endtask

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            n_results++;
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("unexpected result addr %h legit %b status %0d",
                                          result.region_address, result.in_region,
                                          result.status));
            else
            begin
                head = awaited_results.pop_front();
                if (result.region_address !== head.r.region_address)
                    report_mismatch($sformatf("act %0d size %h addr %h: region_address %h, want %h",
                                              head.c.action, head.c.request_size,
                                              head.c.address, result.region_address,
                                              head.r.region_address));
                if (result.in_region !== head.r.in_region)
                    report_mismatch($sformatf("act %0d addr %h: in_region %b, want %b",
                                              head.c.action, head.c.address,
                                              result.in_region, head.r.in_region));
                if (result.status !== head.r.status)
                    report_mismatch($sformatf("act %0d size %h: status %0d, want %0d",
                                              head.c.action, head.c.request_size,
                                              result.status, head.r.status));
            end
        end
    end

    // Region at zero, inclusive bounds, exhaustion, release and the unused action
    task automatic test_directed();
        send_cmd(ACT_ALLOC,   32'd0,          '0);
        send_cmd(ACT_CHECK,   '0,             32'd0);
        send_cmd(ACT_CHECK,   '0,             32'd4096);
        send_cmd(ACT_CHECK,   '0,             32'd4097);
        send_cmd(ACT_CHECK,   '1,             TOP_ADDR);
        send_cmd(ACT_ALLOC,   32'd1023,       '1);
        send_cmd(ACT_ALLOC,   32'd1024,       '0);
        send_cmd(ACT_ALLOC,   '1,             '0);
        send_cmd(ACT_ALLOC,   32'h8000_0000,  '0);
        send_cmd(ACT_CHECK,   '0,             32'd16384);
        send_cmd(ACT_CHECK,   '0,             32'd16385);
        send_cmd(ACT_RELEASE, '1,             32'd5);
        send_cmd(ACT_RELEASE, '0,             32'd0);
        send_cmd(ACT_CHECK,   '0,             32'd0);
        send_cmd(ACT_CHECK,   '0,             32'd4096);
        send_cmd(action_t'(ACT_UNUSED), '1,   '1);
        send_cmd(ACT_RELEASE, '0,             32'd8192);
        send_cmd(ACT_CHECK,   '0,             32'd12000);
    endtask

    // Register writes: ignored index, restart below the free pointer, top of space
    task automatic test_pool_base();
        settle();
        apb_write(ADDR_BAD_REG, 32'hDEAD_B000);
        check_pool_base_readback();
        send_cmd(ACT_ALLOC,   32'd0, '0);
        set_pool_base(32'd4096);
        send_cmd(ACT_ALLOC,   32'd0, '0);
        send_cmd(ACT_RELEASE, '0,    32'd4096);
        send_cmd(ACT_CHECK,   '0,    32'd4096);
        set_pool_base(32'hFFFF_E000);
        send_cmd(ACT_ALLOC,   32'd0, '0);
        send_cmd(ACT_ALLOC,   32'd0, '0);
        send_cmd(ACT_CHECK,   '0,    32'hFFFF_F000);
        send_cmd(ACT_CHECK,   '0,    TOP_ADDR);
        set_pool_base(TOP_ADDR);
        send_cmd(ACT_ALLOC,   32'd0, '0);
        send_cmd(ACT_CHECK,   '0,    TOP_ADDR);
        set_pool_base('0);
        send_cmd(ACT_ALLOC,   32'd0, '0);
        send_cmd(ACT_CHECK,   '0,    32'd0);
    endtask

    // Random mix in four phases, each from its own pool base
    task automatic test_random(input int n_items);
        int                per_phase;
        int                roll;
        logic [ADDR_W-1:0] base;
        per_phase = n_items / 4;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       base = $urandom_range(0, 32'h0FFF_FFFF);
                1:       base = (m_used > 0) ? m_start[$urandom_range(0, m_used - 1)]
                                             : 32'h0000_1000;
                2:       base = 32'hFFF0_0000 | ($urandom() & 32'h000F_FFFF);
                default: base = $urandom();
            endcase
            set_pool_base(base);
            for (int k = 0; k < per_phase; k++)
            begin
                // Switch between idling and back-to-back stretches
                if (k % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                roll = $urandom_range(0, 99);
                if (roll < 42)
                    send_cmd(ACT_ALLOC, pick_size(), $urandom());
                else if (roll < 57)
                    send_cmd(ACT_RELEASE, $urandom(), pick_release_target());
                else if (roll < 95)
                    send_cmd(ACT_CHECK, $urandom(), pick_probe());
                else
                    send_cmd(action_t'(ACT_UNUSED), $urandom(), $urandom());
            end
        end
        no_idle = 1'b0;
    endtask

    // Fill the table, then show that a full table wins over exhaustion
    task automatic test_table_full();
        logic [ADDR_W-1:0] last_start;
        set_pool_base(32'h4000_0000);
        while (m_used < DEPTH)
        begin
            if ($urandom_range(0, 7) == 0)
                send_cmd(ACT_CHECK, $urandom(), pick_probe());
            else
                send_cmd(ACT_ALLOC, $urandom_range(0, 4095), $urandom());
        end
        last_start = m_start[DEPTH-1];
        send_cmd(ACT_ALLOC,   32'd0, '0);
        set_pool_base(TOP_ADDR);
        send_cmd(ACT_ALLOC,   '1,    '0);
        send_cmd(ACT_CHECK,   '0,    last_start);
        send_cmd(ACT_RELEASE, '0,    last_start);
        send_cmd(ACT_CHECK,   '0,    last_start);
        send_cmd(ACT_CHECK,   '0,    pick_probe());
        send_cmd(ACT_ALLOC,   32'd0, '0);
    endtask

    initial
    begin
        clear_model();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_pool_base();
        test_random(RANDOM_ITEMS);
        test_table_full();

        // Drain, then watch for stray results
        settle();
        repeat (END_WAIT) @(posedge clk);

        $display("covered %0d allocations (%0d refused), %0d releases, %0d checks (%0d inside)",
                 n_alloc, n_refused, n_release, n_check, n_legit);
        $display("plus %0d unused-action commands; %0d results seen, %0d mismatches, %0d cycles",
                 n_unused, n_results, err_count, cycle_count);
        if (err_count == 0)
            $display("tb_region_table_bump_allocator_unit OK");
        else
            $display("tb_region_table_bump_allocator_unit NOT OK");
        $finish;
    end

endmodule
